// ===== hdl/pht_pkg.sv =====
`default_nettype none
package pht_pkg;
  localparam int Peers = 16;
  localparam int SlotW = $clog2(Peers);
  localparam int CntW = $clog2(Peers + 1);
  localparam int MaxResults = 16;

  localparam logic [3:0] FnAskInit   = 4'd0;
  localparam logic [3:0] FnRecInit   = 4'd1;
  localparam logic [3:0] FnRecResp   = 4'd2;
  localparam logic [3:0] FnRecOk     = 4'd3;
  localparam logic [3:0] FnRecFail   = 4'd4;
  localparam logic [3:0] FnAskAccept = 4'd5;
  localparam logic [3:0] FnDelay     = 4'd6;
  localparam logic [3:0] FnReset     = 4'd7;
  localparam logic [3:0] FnSweep     = 4'd8;
  localparam logic [3:0] FnPhase     = 4'd9;
  localparam logic [3:0] FnRetries   = 4'd10;
  localparam logic [3:0] FnClear     = 4'd11;

  localparam logic [1:0] PhInit = 2'd0;
  localparam logic [1:0] PhResp = 2'd1;
  localparam logic [1:0] PhOk   = 2'd2;
  localparam logic [1:0] PhFail = 2'd3;

  localparam logic [2:0] RegMyId    = 3'd0;
  localparam logic [2:0] RegTimeout = 3'd1;
  localparam logic [2:0] RegRetry   = 3'd2;
  localparam logic [2:0] RegGap     = 3'd3;
  localparam logic [2:0] RegMaxAtt  = 3'd4;
endpackage
`default_nettype wire

// ===== hdl/peer_handshake_tracker.sv =====
`default_nettype none
// A non-sweep beat scans every slot, then decides and writes the table in the done state,
// from which its result is registered. A sweep scans once per removed peer (at least once),
// gives one result per scan and marks only the final result with last_o.
// Throughput: one item at a time, set by the single shared compare unit stepping one slot
// per cycle; busy drops in the cycle the last result strobe is high. The receiver cannot stall.
// Reset clears all configuration to defaults and every valid bit; entry payload is not reset.
module peer_handshake_tracker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [3:0]   func_i,
  input  wire logic [63:0]  peer_id_i,
  input  wire logic         force_if_stale_i,
  input  wire logic [31:0]  stale_limit_ms_i,
  input  wire logic [31:0]  now_ms_i,
  output logic              res_valid_o,
  output logic              answer_o,
  output logic [2:0]        phase_code_o,
  output logic [31:0]       delay_ms_o,
  output logic              no_retry_o,
  output logic signed [8:0] retry_count_o,
  output logic [63:0]       removed_peer_o,
  output logic              removed_valid_o,
  output logic              table_full_o,
  output logic              last_o
);
  import pht_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  // configuration
  logic [63:0] my_id_q;
  logic [31:0] timeout_q, retry_wait_q, gap_q;
  logic [7:0]  max_att_q;

  // peer table: valid bits in flops, payload without reset
  logic [Peers-1:0] valid_q;
  logic [63:0] peer_q   [Peers];
  logic [1:0]  phase_q  [Peers];
  logic [31:0] time_q   [Peers];
  logic [7:0]  att_q    [Peers];
  logic        retry_q  [Peers];

  // captured item
  logic [3:0]  func_q;
  logic [63:0] id_q;
  logic        force_q;
  logic [31:0] limit_q, now_q;

  // sequencer
  logic [1:0]       st_q;
  logic [SlotW-1:0] idx_q;
  logic             hit_q, free_q, best_q;
  logic [SlotW-1:0] hit_slot_q, free_slot_q, best_slot_q;
  logic [CntW-1:0]  nres_q;
  // stale entries seen in this pass: at least one, at least two
  logic             stale_any_q, stale_more_q;

  // shared per-slot unit: one compare/subtract against the slot under idx_q
  logic [31:0] slot_age;
  logic        slot_match, slot_stale, slot_better;
  always_comb begin
    slot_age    = now_q - time_q[idx_q];
    slot_match  = valid_q[idx_q] && (peer_q[idx_q] == id_q);
    slot_stale  = valid_q[idx_q] && (phase_q[idx_q] == PhInit || phase_q[idx_q] == PhResp)
                  && (slot_age > limit_q);
    slot_better = !best_q || (peer_q[idx_q] < peer_q[best_slot_q]);
  end

  // entry view of the hit slot for the decide cycle
  logic [1:0]  h_ph;
  logic [7:0]  h_att;
  logic        h_rt;
  logic [31:0] h_age;
  always_comb begin
    h_ph  = hit_q ? phase_q[hit_slot_q] : PhInit;
    h_att = hit_q ? att_q[hit_slot_q] : 8'd0;
    h_rt  = retry_q[hit_slot_q];
    h_age = now_q - time_q[hit_slot_q];
  end

  logic             rec_op;
  logic             can_put;
  logic [SlotW-1:0] put_slot;
  logic [1:0]       put_ph;
  logic [7:0]       put_att;
  logic             put_rt;
  logic             ans;
  logic [31:0]      dly;
  logic             nr;
  always_comb begin
    rec_op   = (func_q == FnRecInit) || (func_q == FnRecResp) ||
               (func_q == FnRecOk) || (func_q == FnRecFail);
    can_put  = hit_q || free_q;
    put_slot = hit_q ? hit_slot_q : free_slot_q;
    put_ph   = PhInit;
    put_att  = 8'd0;
    put_rt   = 1'b0;
    case (func_q)
      FnRecInit: put_att = (h_att == 8'hFF) ? 8'hFF : h_att + 8'd1;
      FnRecResp: put_ph = PhResp;
      FnRecOk:   put_ph = PhOk;
      FnRecFail: begin
        put_ph  = PhFail;
        put_att = h_att;
        put_rt  = h_att < max_att_q;
      end
      default: put_ph = PhInit;
    endcase
    // ask_init and ask_accept decision
    ans = 1'b1;
    if (func_q == FnAskAccept) begin
      ans = !(hit_q && h_ph == PhOk);
    end else if (hit_q && (h_ph == PhInit || h_ph == PhResp)) begin
      ans = force_q && h_ph == PhInit && h_age > timeout_q;
    end else if (!(my_id_q < id_q)) begin
      ans = 1'b0;
    end else if (hit_q && h_ph == PhFail) begin
      ans = h_rt && !(h_age < retry_wait_q);
    end
    dly = 32'd0;
    nr  = 1'b0;
    if (hit_q && h_ph == PhFail) begin
      if (!h_rt) begin
        dly = 32'hFFFF_FFFF;
        nr  = 1'b1;
      end else if (h_age < retry_wait_q) begin
        dly = retry_wait_q - h_age;
      end
    end else if (hit_q && h_ph == PhInit && h_age < gap_q) begin
      dly = gap_q - h_age;
    end
  end

  assign busy = (st_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_id_q      <= 64'd0;
      timeout_q    <= 32'd5000;
      retry_wait_q <= 32'd1000;
      gap_q        <= 32'd1000;
      max_att_q    <= 8'd3;
      valid_q      <= '0;
      st_q         <= StIdle;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      best_q       <= 1'b0;
      stale_any_q  <= 1'b0;
      stale_more_q <= 1'b0;
      nres_q       <= '0;
      res_valid_o  <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMyId:    my_id_q <= cfg_data_i;
          RegTimeout: timeout_q <= cfg_data_i[31:0];
          RegRetry:   retry_wait_q <= cfg_data_i[31:0];
          RegGap:     gap_q <= cfg_data_i[31:0];
          RegMaxAtt:  max_att_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      unique case (st_q)
        StIdle: begin
          if (start) begin
            func_q       <= func_i;
            id_q         <= peer_id_i;
            force_q      <= force_if_stale_i;
            limit_q      <= stale_limit_ms_i;
            now_q        <= now_ms_i;
            idx_q        <= '0;
            hit_q        <= 1'b0;
            free_q       <= 1'b0;
            best_q       <= 1'b0;
            stale_any_q  <= 1'b0;
            stale_more_q <= 1'b0;
            nres_q       <= '0;
            st_q         <= StScan;
          end
        end
        StScan: begin
          // advance one slot per cycle through the shared unit
          if (slot_match && !hit_q) begin
            hit_q      <= 1'b1;
            hit_slot_q <= idx_q;
          end
          if (!valid_q[idx_q] && !free_q) begin
            free_q      <= 1'b1;
            free_slot_q <= idx_q;
          end
          if (slot_stale && slot_better) begin
            best_q      <= 1'b1;
            best_slot_q <= idx_q;
          end
          if (slot_stale) begin
            stale_any_q <= 1'b1;
            if (stale_any_q) stale_more_q <= 1'b1;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == SlotW'(Peers - 1)) st_q <= StDone;
        end
        StDone: begin
          answer_o        <= 1'b0;
          phase_code_o    <= 3'd0;
          delay_ms_o      <= 32'd0;
          no_retry_o      <= 1'b0;
          retry_count_o   <= 9'sd0;
          removed_peer_o  <= 64'd0;
          removed_valid_o <= 1'b0;
          table_full_o    <= 1'b0;
          last_o          <= 1'b1;
          res_valid_o     <= 1'b1;
          st_q            <= StIdle;
          case (func_q)
            FnAskInit, FnAskAccept: answer_o <= ans;
            FnDelay: begin
              delay_ms_o <= dly;
              no_retry_o <= nr;
            end
            FnReset: if (hit_q) valid_q[hit_slot_q] <= 1'b0;
            FnPhase: phase_code_o <= hit_q ? {1'b0, h_ph} + 3'd1 : 3'd0;
            FnRetries: retry_count_o <= hit_q ? $signed({1'b0, h_att} - 9'd1) : 9'sd0;
            FnClear: valid_q <= '0;
            FnSweep: begin
              if (best_q) begin
                // drop the lowest stale peer
                valid_q[best_slot_q] <= 1'b0;
                removed_peer_o  <= peer_q[best_slot_q];
                removed_valid_o <= 1'b1;
                nres_q          <= nres_q + 1'b1;
                // another stale peer is left and MaxResults is not reached: hold off last and rescan for it
                if (stale_more_q && nres_q != CntW'(MaxResults - 1)) begin
                  last_o       <= 1'b0;
                  st_q         <= StScan;
                  idx_q        <= '0;
                  best_q       <= 1'b0;
                  stale_any_q  <= 1'b0;
                  stale_more_q <= 1'b0;
                end
              end
            end
            default: ;
          endcase
          if (rec_op) begin
            if (can_put) begin
              valid_q[put_slot]  <= 1'b1;
              peer_q[put_slot]   <= id_q;
              phase_q[put_slot]  <= put_ph;
              time_q[put_slot]   <= now_q;
              att_q[put_slot]    <= put_att;
              retry_q[put_slot]  <= put_rt;
            end else begin
              table_full_o <= 1'b1;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pht_pkg::*;

  // One result beat as the block presents it.
  typedef struct {
    logic              answer;
    logic [2:0]        phase_code;
    logic [31:0]       delay_ms;
    logic              no_retry;
    logic signed [8:0] retry_count;
    logic [63:0]       removed_peer;
    logic              removed_valid;
    logic              table_full;
    logic              last;
  } hs_result_t;

  // Table model plus the queue of results still owed by the block.
  class pht_scoreboard;
    logic [63:0] my_id;
    logic [31:0] timeout_ms, retry_wait, min_gap;
    logic [7:0]  max_att;

    bit          slot_used [Peers];
    logic [63:0] slot_peer [Peers];
    logic [1:0]  slot_phase [Peers];
    logic [31:0] slot_time [Peers];
    logic [7:0]  slot_att [Peers];
    bit          slot_retry [Peers];

    hs_result_t owed [$];
    int errors, items, results, removed, full_hits;

    function void power_on();
      my_id = '0; timeout_ms = 32'd5000; retry_wait = 32'd1000; min_gap = 32'd1000;
      max_att = 8'd3;
      foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
        RegMyId:    my_id = d;
        RegTimeout: timeout_ms = d[31:0];
        RegRetry:   retry_wait = d[31:0];
        RegGap:     min_gap = d[31:0];
        RegMaxAtt:  max_att = d[7:0];
        default: ;
      endcase
    endfunction

    function int lookup(logic [63:0] id);
      for (int i = 0; i < Peers; i++)
        if (slot_used[i] && slot_peer[i] == id) return i;
      return -1;
    endfunction

    // Store an entry; returns 0 when the peer is new and no slot is free.
    function bit store(logic [63:0] id, logic [1:0] ph, logic [31:0] t,
                       logic [7:0] att, bit rt);
      int s;
      s = lookup(id);
      if (s < 0)
        for (int i = 0; i < Peers; i++)
          if (!slot_used[i]) begin
            s = i;
            break;
          end
      if (s < 0) return 0;
      slot_used[s] = 1; slot_peer[s] = id; slot_phase[s] = ph;
      slot_time[s] = t; slot_att[s] = att; slot_retry[s] = rt;
      return 1;
    endfunction

    // Note an accepted beat and queue every result it must produce.
    function void note_item(logic [3:0] fn, logic [63:0] id, logic frc,
                            logic [31:0] lim, logic [31:0] now);
      hs_result_t r;
      int s, best;
      logic [31:0] age;
      logic [1:0] ph;
      logic [7:0] att;
      bit ok;
      items++;
      r = '{default: '0};
      s = lookup(id);
      age = (s >= 0) ? now - slot_time[s] : '0;
      ph = (s >= 0) ? slot_phase[s] : PhInit;
      att = (s >= 0) ? slot_att[s] : '0;
      ok = 1;
      case (fn)
        FnAskInit: begin
          r.answer = 1;
          if (s >= 0 && (ph == PhInit || ph == PhResp))
            r.answer = frc && ph == PhInit && age > timeout_ms;
          else if (!(my_id < id))
            r.answer = 0;
          else if (s >= 0 && ph == PhFail && (!slot_retry[s] || age < retry_wait))
            r.answer = 0;
        end
        FnRecInit:   ok = store(id, PhInit, now, (att == 8'hff) ? att : att + 8'd1, 0);
        FnRecResp:   ok = store(id, PhResp, now, 8'd0, 0);
        FnRecOk:     ok = store(id, PhOk, now, 8'd0, 0);
        FnRecFail:   ok = store(id, PhFail, now, att, att < max_att);
        FnAskAccept: r.answer = !(s >= 0 && ph == PhOk);
        FnDelay: begin
          if (s >= 0 && ph == PhFail) begin
            if (!slot_retry[s]) begin
              r.delay_ms = '1;
              r.no_retry = 1;
            end else if (age < retry_wait) r.delay_ms = retry_wait - age;
          end else if (s >= 0 && ph == PhInit && age < min_gap)
            r.delay_ms = min_gap - age;
        end
        FnReset: if (s >= 0) slot_used[s] = 0;
        FnSweep: begin
          // Remove stale open handshakes, lowest peer id first.
          for (int k = 0; k < MaxResults; k++) begin
            best = -1;
            for (int i = 0; i < Peers; i++) begin
              if (!slot_used[i] || !(slot_phase[i] == PhInit || slot_phase[i] == PhResp))
                continue;
              if (now - slot_time[i] <= lim) continue;
              if (best < 0 || slot_peer[i] < slot_peer[best]) best = i;
            end
            if (best < 0) break;
            slot_used[best] = 0;
            if (k > 0) owed = {owed, r};
            r = '{default: '0};
            r.removed_peer = slot_peer[best];
            r.removed_valid = 1;
            removed++;
          end
        end
        FnPhase:   r.phase_code = (s >= 0) ? {1'b0, ph} + 3'd1 : 3'd0;
        FnRetries: if (s >= 0) r.retry_count = $signed({1'b0, att} - 9'd1);
        FnClear:   foreach (slot_used[i]) slot_used[i] = 0;
        default: ;
      endcase
      r.table_full = !ok;
      if (!ok) full_hits++;
      r.last = 1;
      owed = {owed, r};
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(hs_result_t a);
      hs_result_t e;
      results++;
      if (owed.size() == 0) begin
        $error("result beat with nothing outstanding");
        errors++;
        return;
      end
      e = owed.pop_front();
      cmp("answer", e.answer, a.answer);
      cmp("phase_code", e.phase_code, a.phase_code);
      cmp("delay_ms", e.delay_ms, a.delay_ms);
      cmp("no_retry", e.no_retry, a.no_retry);
      cmp("retry_count", 64'(e.retry_count[8:0]), 64'(a.retry_count[8:0]));
      cmp("removed_peer", e.removed_peer, a.removed_peer);
      cmp("removed_valid", e.removed_valid, a.removed_valid);
      cmp("table_full", e.table_full, a.table_full);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [63:0] cfg_data_i;
  logic start, busy;
  logic [3:0] func_i;
  logic [63:0] peer_id_i;
  logic force_if_stale_i;
  logic [31:0] stale_limit_ms_i, now_ms_i;
  logic res_valid_o, answer_o, no_retry_o, removed_valid_o, table_full_o, last_o;
  logic [2:0] phase_code_o;
  logic [31:0] delay_ms_o;
  logic signed [8:0] retry_count_o;
  logic [63:0] removed_peer_o;

  peer_handshake_tracker uut (.*);

  pht_scoreboard sb;
  logic [63:0] id_pool [24];
  logic [31:0] clock_ms;
  int idle_pct;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sample at the edge; the driver only changes inputs through NBAs.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      sb.note_item(func_i, peer_id_i, force_if_stale_i, stale_limit_ms_i, now_ms_i);
    if (rst_ni && res_valid_o)
      sb.check_result('{answer_o, phase_code_o, delay_ms_o, no_retry_o, retry_count_o,
                        removed_peer_o, removed_valid_o, table_full_o, last_o});
  end

  // Present one beat and hold start until the block takes it; start stays high
  // unless this beat is followed by idle cycles.
  task automatic send(logic [3:0] fn, logic [63:0] id, logic frc, logic [31:0] lim,
                      logic [31:0] now);
    start <= 1;
    func_i <= fn; peer_id_i <= id; force_if_stale_i <= frc;
    stale_limit_ms_i <= lim; now_ms_i <= now;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every owed beat has come back, plus the scan time.
  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (sb.owed.size() != 0 || busy) @(posedge clk_i);
    repeat (Peers + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [63:0] id, logic [31:0] to, logic [31:0] rw,
                          logic [31:0] gap, logic [7:0] ma);
    write_reg(RegMyId, id);
    write_reg(RegTimeout, to);
    write_reg(RegRetry, rw);
    write_reg(RegGap, gap);
    write_reg(RegMaxAtt, {56'd0, ma});
  endtask

  // Mostly handshake traffic on a small peer set, with queries, sweeps and
  // the occasional wild beat.
  task automatic random_phase(int n);
    logic [3:0] fn;
    logic [63:0] id;
    logic [31:0] lim;
    int w;
    for (int k = 0; k < n; k++) begin
      w = $urandom_range(99);
      if (w < 12)      fn = FnRecInit;
      else if (w < 20) fn = FnRecResp;
      else if (w < 26) fn = FnRecOk;
      else if (w < 34) fn = FnRecFail;
      else if (w < 44) fn = FnAskInit;
      else if (w < 50) fn = FnAskAccept;
      else if (w < 60) fn = FnDelay;
      else if (w < 66) fn = FnPhase;
      else if (w < 72) fn = FnRetries;
      else if (w < 78) fn = FnReset;
      else if (w < 92) fn = FnSweep;
      else if (w < 94) fn = FnClear;
      else             fn = 4'($urandom_range(12, 15));
      id = ($urandom_range(19) == 0) ? {$urandom, $urandom} : id_pool[$urandom_range(23)];
      lim = ($urandom_range(9) == 0) ? $urandom : $urandom_range(800);
      clock_ms += ($urandom_range(15) == 0) ? $urandom : $urandom_range(150);
      send(fn, id, 1'($urandom_range(1)), lim, clock_ms);
      if (k == n / 2) drain();  // hold off until the block has caught up
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.power_on();
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0; start = 0;
    func_i = '0; peer_id_i = '0; force_if_stale_i = 0; stale_limit_ms_i = '0; now_ms_i = '0;
    idle_pct = 31;
    clock_ms = 32'hffff_ff00;
    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = 64'h8000_0000_0000_0000;
    id_pool[3] = 64'h7fff_ffff_ffff_ffff;
    for (int i = 4; i < 24; i++) id_pool[i] = {$urandom, $urandom};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty-table queries, records in every handshake phase, sweeps, unused codes.
    send(FnPhase, id_pool[1], 0, 0, 32'd0);
    send(FnRetries, id_pool[1], 0, 0, 32'd0);
    send(FnAskAccept, id_pool[1], 0, 0, 32'd0);
    send(FnAskInit, id_pool[0], 0, 0, 32'd0);
    send(FnAskInit, id_pool[1], 0, 0, 32'd0);
    send(FnRecInit, id_pool[1], 0, 0, 32'hffff_ffff);
    send(FnAskInit, id_pool[1], 1, 0, 32'd100);
    send(FnDelay, id_pool[1], 0, 0, 32'd100);
    send(FnAskInit, id_pool[1], 1, 0, 32'd6000);
    send(FnRecResp, id_pool[2], 0, 0, 32'd10);
    send(FnRetries, id_pool[2], 0, 0, 32'd10);
    send(FnRecFail, id_pool[1], 0, 0, 32'd200);
    send(FnDelay, id_pool[1], 0, 0, 32'd300);
    send(FnAskInit, id_pool[1], 0, 0, 32'd300);
    send(FnRecOk, id_pool[3], 0, 0, 32'd400);
    send(FnAskAccept, id_pool[3], 0, 0, 32'd400);
    send(FnPhase, id_pool[3], 0, 0, 32'd400);
    send(FnSweep, '0, 0, 32'd0, 32'd9000);
    send(FnSweep, '0, 0, 32'hffff_ffff, 32'd9000);
    send(FnReset, id_pool[1], 0, 0, 32'd9000);
    send(FnPhase, id_pool[1], 0, 0, 32'd9000);
    send(FnClear, '0, 0, 0, 32'd9000);
    send(4'd12, '1, 1, '1, '1);
    send(4'd15, '0, 0, 0, 0);
    drain();

    idle_pct = 31;
    set_regs($urandom_range(3) == 0 ? '0 : {$urandom, $urandom}, 32'd300, 32'd200,
             32'd150, 8'd2);
    write_reg(3'd7, '1);  // unmapped index, must be ignored
    random_phase(80);

    idle_pct = 49;
    set_regs('1, '0, '0, '0, 8'd0);
    random_phase(30);
    set_regs(64'h8000_0000_0000_0000, '1, '1, '1, 8'd255);
    random_phase(56);

    idle_pct = 0;
    set_regs({$urandom, $urandom}, $urandom_range(400), $urandom_range(400),
             $urandom_range(400), 8'($urandom_range(5)));
    random_phase(80);

    repeat (2 * Peers) @(posedge clk_i);
    $display("Covered %0d beats, %0d results, %0d sweep removals, %0d table-full drops",
             sb.items, sb.results, sb.removed, sb.full_hits);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
